@@ design/r8lae_pkg.sv @@
// shared types, opcode codes and helpers for the r8 load and alu executor
package r8lae_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 16;
    localparam int FLAG_W = 4;
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = 3;

    // flag bit positions inside the flag nibble
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // opcode groups in bits 7:6
    localparam logic [1:0] GRP_LOAD = 2'b01;
    localparam logic [1:0] GRP_ALU  = 2'b10;

    localparam logic [7:0] OPC_HALT = 8'h76;

    // register operand codes as they appear in the opcode
    localparam logic [2:0] RCODE_H      = 3'd4;
    localparam logic [2:0] RCODE_L      = 3'd5;
    localparam logic [2:0] RCODE_HL_MEM = 3'd6;
    localparam logic [2:0] RCODE_A      = 3'd7;

    // register file slots
    localparam logic [REG_IDX_W-1:0] RIDX_H = 3'd4;
    localparam logic [REG_IDX_W-1:0] RIDX_L = 3'd5;
    localparam logic [REG_IDX_W-1:0] RIDX_A = 3'd6;

    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [FLAG_W-1:0] flags_t;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } alu_op_t;

    // alu result bundle
    typedef struct packed {
        byte_t  result;
        flags_t flags;
        logic   write_acc;
    } alu_out_t;

    // operand code to register file slot; A sits in the last slot
    function automatic logic [REG_IDX_W-1:0] reg_index(input logic [2:0] code);
        logic [REG_IDX_W-1:0] idx;
        begin
            if (code == RCODE_A || code == RCODE_HL_MEM) begin
                idx = RIDX_A;
            end else begin
                idx = code;
            end
            return idx;
        end
    endfunction

endpackage

@@ design/r8_load_and_alu_executor.sv @@
// Executes one opcode from 0x40..0xBF per beat (register loads, HALT, and the eight
// accumulator alu operations) against seven internal 8-bit registers and the Z/N/H/C
// flags, all cleared by reset. A beat is taken into an input register and, once the
// output register is free, decoded, read from the register file, run through the
// 8-bit alu and written back while its result lands in the output register. One beat
// is accepted every clock while results are taken. A stalled result holds the output
// register and the input register, and the input side stays ready while a waiting
// result is being taken. mem_address is HL before the instruction; loads with
// destination (HL) report mem_write with the stored byte, otherwise the store byte
// is zero. Opcodes outside 0x40..0xBF change nothing.
module r8_load_and_alu_executor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  r8lae_pkg::byte_t   s_opcode,
    input  r8lae_pkg::byte_t   s_mem_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_mem_write,
    output logic [15:0]        m_mem_address,
    output r8lae_pkg::byte_t   m_mem_write_data,
    output logic               m_halt_seen,
    output r8lae_pkg::byte_t   m_acc_value,
    output r8lae_pkg::flags_t  m_flag_bits
);
    import r8lae_pkg::*;

    // input register
    logic   in_valid_reg;
    byte_t  in_opcode_reg;
    byte_t  in_mem_data_reg;

    // architectural state
    byte_t  reg_file_reg [REG_COUNT];
    byte_t  reg_file_next [REG_COUNT];
    flags_t flags_reg;
    flags_t flags_next;

    // output register
    logic              out_valid_reg;
    logic              out_mem_write_reg;
    logic [ADDR_W-1:0] out_mem_address_reg;
    byte_t             out_mem_write_data_reg;
    logic              out_halt_seen_reg;
    byte_t             out_acc_value_reg;
    flags_t            out_flag_bits_reg;

    logic     out_free;
    logic     exec;
    logic [2:0] dst_code;
    logic [2:0] src_code;
    logic     is_halt;
    logic     is_load;
    logic     is_alu;
    logic     is_store;
    byte_t    src_val;
    alu_out_t alu_out;

    // pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign exec     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // opcode decode
    assign dst_code = in_opcode_reg[5:3];
    assign src_code = in_opcode_reg[2:0];
    assign is_halt  = (in_opcode_reg == OPC_HALT);
    assign is_load  = (in_opcode_reg[7:6] == GRP_LOAD) && !is_halt;
    assign is_alu   = (in_opcode_reg[7:6] == GRP_ALU);
    assign is_store = is_load && (dst_code == RCODE_HL_MEM);

    // source operand: register or memory byte at hl
    assign src_val = (src_code == RCODE_HL_MEM) ? in_mem_data_reg
                                                : reg_file_reg[reg_index(src_code)];

    r8lae_alu u_alu (
        .acc        (reg_file_reg[RIDX_A]),
        .operand    (src_val),
        .op         (alu_op_t'(dst_code)),
        .carry_flag (flags_reg[FLAG_C]),
        .alu_out    (alu_out)
    );

    // state write-back
    always_comb begin
        reg_file_next = reg_file_reg;
        flags_next    = flags_reg;
        if (is_load && !is_store) begin
            reg_file_next[reg_index(dst_code)] = src_val;
        end
        if (is_alu) begin
            flags_next = alu_out.flags;
            if (alu_out.write_acc) begin
                reg_file_next[RIDX_A] = alu_out.result;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_opcode_reg   <= s_opcode;
            in_mem_data_reg <= s_mem_data;
        end
    end

    // register file and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                reg_file_reg[i] <= '0;
            end
            flags_reg <= '0;
        end else if (exec) begin
            reg_file_reg <= reg_file_next;
            flags_reg    <= flags_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (exec) begin
            out_mem_write_reg      <= is_store;
            out_mem_address_reg    <= {reg_file_reg[RIDX_H], reg_file_reg[RIDX_L]};
            out_mem_write_data_reg <= is_store ? src_val : '0;
            out_halt_seen_reg      <= is_halt;
            out_acc_value_reg      <= reg_file_next[RIDX_A];
            out_flag_bits_reg      <= flags_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mem_write      = out_mem_write_reg;
    assign m_mem_address    = out_mem_address_reg;
    assign m_mem_write_data = out_mem_write_data_reg;
    assign m_halt_seen      = out_halt_seen_reg;
    assign m_acc_value      = out_acc_value_reg;
    assign m_flag_bits      = out_flag_bits_reg;

    // halt never reports a store
    a_halt_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_halt_seen_reg |-> !out_mem_write_reg)
        else $error("halt result reports a store");

    // store byte is zero unless a store is reported
    a_store_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_mem_write_reg |-> out_mem_write_data_reg == '0)
        else $error("store byte nonzero without store");

    // compare leaves the accumulator untouched
    a_cp_keeps_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && is_alu && dst_code == ALU_CP
        |=> reg_file_reg[RIDX_A] == $past(reg_file_reg[RIDX_A]))
        else $error("compare changed accumulator");

    // reported accumulator matches the state
    a_acc_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        exec |=> out_acc_value_reg == reg_file_reg[RIDX_A] && out_flag_bits_reg == flags_reg)
        else $error("result disagrees with architectural state");

    // state holds while no beat executes
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !exec |=> $stable(flags_reg) && $stable(reg_file_reg[RIDX_A]))
        else $error("state changed without an executed beat");

endmodule

@@ design/r8lae_alu.sv @@
// 8-bit accumulator alu with z, n, h, c flag generation
module r8lae_alu (
    input  r8lae_pkg::byte_t   acc,
    input  r8lae_pkg::byte_t   operand,
    input  r8lae_pkg::alu_op_t op,
    input  logic               carry_flag,
    output r8lae_pkg::alu_out_t alu_out
);
    import r8lae_pkg::*;

    logic          cin;
    logic [DATA_W:0] sum_full;
    logic [4:0]    sum_low;
    logic [DATA_W:0] diff_full;
    logic [4:0]    diff_low;
    byte_t         res;
    flags_t        flg;

    // carry in only for the with-carry forms
    assign cin = (op == ALU_ADC || op == ALU_SBC) ? carry_flag : 1'b0;

    // adder and subtractor with nibble and byte carries
    assign sum_full  = {1'b0, acc} + {1'b0, operand} + {{DATA_W{1'b0}}, cin};
    assign sum_low   = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
    assign diff_full = {1'b0, acc} - {1'b0, operand} - {{DATA_W{1'b0}}, cin};
    assign diff_low  = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};

    // operation select
    always_comb begin
        flg = '0;
        res = acc;
        case (op)
            ALU_ADD, ALU_ADC: begin
                res         = sum_full[DATA_W-1:0];
                flg[FLAG_H] = sum_low[4];
                flg[FLAG_C] = sum_full[DATA_W];
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                res         = diff_full[DATA_W-1:0];
                flg[FLAG_N] = 1'b1;
                flg[FLAG_H] = diff_low[4];
                flg[FLAG_C] = diff_full[DATA_W];
            end
            ALU_AND: begin
                res         = acc & operand;
                flg[FLAG_H] = 1'b1;
            end
            ALU_XOR: begin
                res = acc ^ operand;
            end
            default: begin
                res = acc | operand;
            end
        endcase
        flg[FLAG_Z] = (res == '0);
    end

    assign alu_out.result    = res;
    assign alu_out.flags     = flg;
    assign alu_out.write_acc = (op != ALU_CP);

endmodule

@@ tb/r8lae_exec_checker.sv @@
// channel monitor, opcode predictor and result comparison for the r8 load and alu executor
`timescale 1ns / 100ps

module r8lae_exec_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  r8lae_pkg::byte_t      s_opcode,
    input  r8lae_pkg::byte_t      s_mem_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_mem_write,
    input  logic [15:0]           m_mem_address,
    input  r8lae_pkg::byte_t      m_mem_write_data,
    input  logic                  m_halt_seen,
    input  r8lae_pkg::byte_t      m_acc_value,
    input  r8lae_pkg::flags_t     m_flag_bits,
    output int unsigned           mismatch_count,
    output int unsigned           results_owed
);
    import r8lae_pkg::*;

    // one result beat as the block should report it
    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_address;
        byte_t       write_data;
        logic        halt;
        byte_t       acc;
        flags_t      flags;
    } exec_beat_t;

    exec_beat_t owed_q[$];

    // shadow registers indexed by operand code; slot 6 (memory at HL) stays unused
    byte_t  gpr [8];
    flags_t znhc;

    // run one opcode on the shadow state and return the beat it should produce
    function automatic exec_beat_t execute_opcode(input byte_t opc, input byte_t mem);
        exec_beat_t  r;
        logic [2:0]  dst;
        logic [2:0]  src;
        alu_op_t     op;
        byte_t       a;
        byte_t       operand;
        logic        cin;
        logic [8:0]  wide;
        logic [4:0]  nib;
        flags_t      f;
        dst = opc[5:3];
        src = opc[2:0];
        r = '0;
        r.mem_address = {gpr[RCODE_H], gpr[RCODE_L]};
        operand = (src == RCODE_HL_MEM) ? mem : gpr[src];
        if (opc[7:6] == GRP_LOAD) begin
            if (opc == OPC_HALT) begin
                r.halt = 1'b1;
            end else if (dst == RCODE_HL_MEM) begin
                r.mem_write  = 1'b1;
                r.write_data = operand;
            end else begin
                gpr[dst] = operand;
            end
        end else if (opc[7:6] == GRP_ALU) begin
            op   = alu_op_t'(dst);
            a    = gpr[RCODE_A];
            cin  = znhc[FLAG_C];
            f    = '0;
            wide = '0;
            nib  = '0;
            case (op)
                ALU_ADD, ALU_ADC: begin
                    if (op == ALU_ADD) cin = 1'b0;
                    wide = 9'(a) + 9'(operand) + 9'(cin);
                    nib  = 5'(a[3:0]) + 5'(operand[3:0]) + 5'(cin);
                    f[FLAG_H] = nib[4];
                    f[FLAG_C] = wide[8];
                end
                ALU_SUB, ALU_SBC, ALU_CP: begin
                    // borrow shows up in the bit above each field
                    if (op != ALU_SBC) cin = 1'b0;
                    wide = 9'(a) - 9'(operand) - 9'(cin);
                    nib  = 5'(a[3:0]) - 5'(operand[3:0]) - 5'(cin);
                    f[FLAG_N] = 1'b1;
                    f[FLAG_H] = nib[4];
                    f[FLAG_C] = wide[8];
                end
                ALU_AND: begin
                    wide = {1'b0, a & operand};
                    f[FLAG_H] = 1'b1;
                end
                ALU_XOR: wide = {1'b0, a ^ operand};
                default: wide = {1'b0, a | operand};
            endcase
            f[FLAG_Z] = (wide[7:0] == 8'h00);
            znhc = f;
            // compare leaves the accumulator alone
            if (op != ALU_CP) gpr[RCODE_A] = wide[7:0];
        end
        r.acc   = gpr[RCODE_A];
        r.flags = znhc;
        return r;
    endfunction

    // check result beats against the oldest prediction, then predict new input beats
    always @(posedge aclk) begin : watch
        exec_beat_t want;
        exec_beat_t got;
        logic       bad;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) gpr[i] = '0;
            znhc = '0;
            owed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_mem_write, m_mem_address, m_mem_write_data, m_halt_seen,
                       m_acc_value, m_flag_bits};
                if (owed_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: result beat with none outstanding: ",
                                  "wr=%0b addr=%h wd=%h halt=%0b a=%h f=%b"},
                                 $realtime, got.mem_write, got.mem_address, got.write_data,
                                 got.halt, got.acc, got.flags);
                end else begin
                    want = owed_q.pop_front();
                    bad = (got.mem_write   !== want.mem_write)
                       || (got.mem_address !== want.mem_address)
                       || (got.write_data  !== want.write_data)
                       || (got.halt        !== want.halt)
                       || (got.acc         !== want.acc)
                       || (got.flags       !== want.flags);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch exp wr=%0b addr=%h wd=%h halt=%0b a=%h f=%b",
                                     $realtime, want.mem_write, want.mem_address,
                                     want.write_data, want.halt, want.acc, want.flags);
                            $display("%0t:          got wr=%0b addr=%h wd=%h halt=%0b a=%h f=%b",
                                     $realtime, got.mem_write, got.mem_address,
                                     got.write_data, got.halt, got.acc, got.flags);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                owed_q.push_back(execute_opcode(s_opcode, s_mem_data));
        end
        results_owed = owed_q.size();
    end

endmodule

@@ tb/tb_r8_load_and_alu_executor.sv @@
// stimulus, handshake pacing and verdict for the r8 load and alu executor
`timescale 1ns / 100ps

module tb_r8_load_and_alu_executor;
    import r8lae_pkg::*;

    localparam int RANDOM_BEATS    = 680;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    byte_t       s_opcode;
    byte_t       s_mem_data;
    logic        m_valid;
    logic        m_ready;
    logic        m_mem_write;
    logic [15:0] m_mem_address;
    byte_t       m_mem_write_data;
    logic        m_halt_seen;
    byte_t       m_acc_value;
    flags_t      m_flag_bits;

    int unsigned mismatch_count;
    int unsigned results_owed;
    int          idle_cycles;
    int          sender_calm;
    bit          hold_request;

    r8_load_and_alu_executor u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_mem_data       (s_mem_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mem_write      (m_mem_write),
        .m_mem_address    (m_mem_address),
        .m_mem_write_data (m_mem_write_data),
        .m_halt_seen      (m_halt_seen),
        .m_acc_value      (m_acc_value),
        .m_flag_bits      (m_flag_bits)
    );

    r8lae_exec_checker u_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_mem_data       (s_mem_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mem_write      (m_mem_write),
        .m_mem_address    (m_mem_address),
        .m_mem_write_data (m_mem_write_data),
        .m_halt_seen      (m_halt_seen),
        .m_acc_value      (m_acc_value),
        .m_flag_bits      (m_flag_bits),
        .mismatch_count   (mismatch_count),
        .results_owed     (results_owed)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // wait before the next beat: random, with occasional runs of back-to-back beats
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // memory byte with the edge values weighted up
    function automatic byte_t pick_mem_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return ($urandom_range(0, 1) != 0) ? 8'h0F : 8'hF0;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one instruction beat and hold it until taken
    task automatic send_beat(input byte_t opc, input byte_t mem);
        int gap;
        gap = draw_wait(sender_calm);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid    = 1'b0;
            s_opcode   = byte_t'($urandom_range(0, 255));
            s_mem_data = byte_t'($urandom_range(0, 255));
            repeat (gap) @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_opcode   = opc;
        s_mem_data = mem;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side pacing, with one long hold-off on request
    initial begin : receiver
        int gap;
        int calm_left;
        bit held;
        calm_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        wait (aresetn);
        forever begin
            gap = draw_wait(calm_left);
            @(negedge aclk);
            if (hold_request && !held) begin
                held    = 1'b1;
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // reset, directed beats, random beats, drain and verdict
    initial begin : stimulus
        byte_t opc;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = '0;
        s_mem_data   = '0;
        sender_calm  = 0;
        hold_request = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // ld a,(hl) / ld b,(hl), then add wrapping to zero with half and full carry
        send_beat(8'h7E, 8'hFF);
        send_beat(8'h46, 8'h01);
        send_beat(8'h80, 8'h00);
        // adc picks up the carry, sub to zero, sbc with and without borrow in
        send_beat(8'h7E, 8'h0F);
        send_beat(8'h8E, 8'h00);
        send_beat(8'h96, 8'h10);
        send_beat(8'h9E, 8'h01);
        send_beat(8'h9E, 8'h00);
        // logic operations
        send_beat(8'h7E, 8'hF0);
        send_beat(8'hA6, 8'h0F);
        send_beat(8'hAE, 8'hFF);
        send_beat(8'hB6, 8'h00);
        // compare leaves a unchanged, equal and against itself
        send_beat(8'hBE, 8'hFF);
        send_beat(8'hBF, 8'h00);
        // set hl, then stores to memory at hl
        send_beat(8'h66, 8'hAB);
        send_beat(8'h6E, 8'hCD);
        send_beat(8'h77, 8'h55);
        send_beat(8'h70, 8'hAA);
        // halt, the lowest opcode, register-to-register copies and alu on registers
        send_beat(OPC_HALT, 8'hFF);
        send_beat(8'h40, 8'h00);
        send_beat(8'h4F, 8'h12);
        send_beat(8'h91, 8'h34);
        send_beat(8'hBC, 8'h00);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == 150) hold_request = 1'b1;
            if (i == 400) begin
                // let the block run completely dry before carrying on
                @(negedge aclk);
                s_valid = 1'b0;
                while (results_owed != 0) @(negedge aclk);
            end
            opc = byte_t'($urandom_range(8'h40, 8'hBF));
            send_beat(opc, pick_mem_byte());
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
